### rtl/sntl_pkg.sv
// Shared types, limits and glyph tables for the signed number to LED matrix rows block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sntl_pkg;

	localparam int VALUE_W = 16;
	localparam int ROW_W   = 8;
	localparam int MAG_W   = 11;
	localparam int REM_W   = 10;
	localparam int DIGIT_W = 4;

	localparam logic signed [VALUE_W-1:0] LIMIT_POS = 16'sd1999;
	localparam logic signed [VALUE_W-1:0] LIMIT_NEG = -16'sd1999;
	localparam logic [MAG_W-1:0] THOUSAND = 11'd1000;

	// Digits and flags of one clamped value
	typedef struct packed {
		logic               neg;
		logic               thou;
		logic [DIGIT_W-1:0] hund;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] units;
	} digits_t;

	// One full matrix image
	typedef struct packed {
		logic [ROW_W-1:0] row0;
		logic [ROW_W-1:0] row1;
		logic [ROW_W-1:0] row2;
		logic [ROW_W-1:0] row3;
		logic [ROW_W-1:0] row4;
		logic [ROW_W-1:0] row5;
		logic [ROW_W-1:0] row6;
		logic [ROW_W-1:0] row7;
	} rows_t;

	// 3x5 glyph, packed {r4, r3, r2, r1, r0}, 3 bits per row
	function automatic logic [14:0] font_glyph(input logic [DIGIT_W-1:0] d);
		logic [14:0] g;
		case (d)
			4'd0:    g = {3'h7, 3'h5, 3'h5, 3'h5, 3'h7};
			4'd1:    g = {3'h4, 3'h4, 3'h4, 3'h4, 3'h4};
			4'd2:    g = {3'h7, 3'h1, 3'h7, 3'h4, 3'h7};
			4'd3:    g = {3'h7, 3'h4, 3'h7, 3'h4, 3'h7};
			4'd4:    g = {3'h4, 3'h4, 3'h7, 3'h5, 3'h5};
			4'd5:    g = {3'h7, 3'h4, 3'h7, 3'h1, 3'h7};
			4'd6:    g = {3'h7, 3'h5, 3'h7, 3'h1, 3'h7};
			4'd7:    g = {3'h4, 3'h4, 3'h4, 3'h4, 3'h7};
			4'd8:    g = {3'h7, 3'h5, 3'h7, 3'h5, 3'h7};
			4'd9:    g = {3'h7, 3'h4, 3'h7, 3'h5, 3'h7};
			default: g = '0;
		endcase
		return g;
	endfunction

	// Bar graph, packed {row6, row7}
	function automatic logic [15:0] bar_rows(input logic [DIGIT_W-1:0] d);
		logic [15:0] b;
		case (d)
			4'd0:    b = {8'h00, 8'h00};
			4'd1:    b = {8'h00, 8'h40};
			4'd2:    b = {8'h40, 8'h60};
			4'd3:    b = {8'h60, 8'h70};
			4'd4:    b = {8'h70, 8'h78};
			4'd5:    b = {8'h78, 8'h7c};
			4'd6:    b = {8'h7c, 8'h7e};
			4'd7:    b = {8'h7e, 8'h7f};
			4'd8:    b = {8'h7f, 8'hff};
			4'd9:    b = {8'hff, 8'hff};
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### rtl/sntl_in_if.sv
// Input channel: valid/ready handshake carrying one signed value per beat.
// Depends on sntl_pkg.
`default_nettype none

interface sntl_in_if
	import sntl_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### rtl/sntl_out_if.sv
// Output channel: valid/ready handshake carrying the eight matrix rows per beat.
// Depends on sntl_pkg.
`default_nettype none

interface sntl_out_if
	import sntl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row0;
	logic [ROW_W-1:0] row1;
	logic [ROW_W-1:0] row2;
	logic [ROW_W-1:0] row3;
	logic [ROW_W-1:0] row4;
	logic [ROW_W-1:0] row5;
	logic [ROW_W-1:0] row6;
	logic [ROW_W-1:0] row7;

	modport source (output valid, output row0, output row1, output row2, output row3,
		output row4, output row5, output row6, output row7, input ready);
	modport sink   (input valid, input row0, input row1, input row2, input row3,
		input row4, input row5, input row6, input row7, output ready);
endinterface

`default_nettype wire

### rtl/sntl_split.sv
// Clamp, sign/magnitude and decimal digit split of one value (combinational).
// Depends on sntl_pkg.
`default_nettype none

module sntl_split
	import sntl_pkg::*;
(
	input  wire logic signed [VALUE_W-1:0] value,
	output digits_t                        digits
);

	logic             sat_hi;
	logic             sat_lo;
	logic             neg;
	logic [VALUE_W-1:0] abs_v;
	logic [MAG_W-1:0] mag;
	logic             thou;
	logic [REM_W-1:0] m3;
	logic [DIGIT_W-1:0] hund;
	logic [6:0]       rem;
	logic [DIGIT_W-1:0] tens;
	logic [DIGIT_W-1:0] units;

	assign sat_hi = (value > LIMIT_POS);
	assign sat_lo = (value < LIMIT_NEG);
	assign neg    = value[VALUE_W-1];
	assign abs_v  = neg ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
	assign mag    = (sat_hi || sat_lo) ? MAG_W'(LIMIT_POS) : abs_v[MAG_W-1:0];
	assign thou   = (mag >= THOUSAND);
	assign m3     = thou ? REM_W'(mag - THOUSAND) : mag[REM_W-1:0];

	// digit = number of thresholds at or below the remainder
	always_comb begin
		hund = '0;
		for (int k = 1; k < 10; k++) begin
			hund = hund + DIGIT_W'(m3 >= REM_W'(k * 100));
		end
	end

	assign rem = 7'(m3 - (REM_W'(hund) * REM_W'(100)));

	always_comb begin
		tens = '0;
		for (int k = 1; k < 10; k++) begin
			tens = tens + DIGIT_W'(rem >= 7'(k * 10));
		end
	end

	assign units = DIGIT_W'(rem - (7'(tens) * 7'd10));

	assign digits = '{neg: neg, thou: thou, hund: hund, tens: tens, units: units};

endmodule

`default_nettype wire

### rtl/sntl_render.sv
// Glyph and bar-graph lookup that turns digits and flags into matrix rows.
// Depends on sntl_pkg.
`default_nettype none

module sntl_render
	import sntl_pkg::*;
(
	input  wire digits_t digits,
	output rows_t        rows
);

	logic [14:0] hg;
	logic [14:0] tg;
	logic [15:0] bar;

	assign hg  = font_glyph(digits.hund);
	assign tg  = font_glyph(digits.tens);
	assign bar = bar_rows(digits.units);

	assign rows.row0 = {1'b0,        tg[2:0],   1'b0, hg[2:0]};
	assign rows.row1 = {1'b0,        tg[5:3],   1'b0, hg[5:3]};
	assign rows.row2 = {digits.neg,  tg[8:6],   1'b0, hg[8:6]};
	assign rows.row3 = {1'b0,        tg[11:9],  1'b0, hg[11:9]};
	assign rows.row4 = {1'b0,        tg[14:12], 1'b0, hg[14:12]};
	assign rows.row5 = {digits.thou, 7'd0};
	assign rows.row6 = bar[15:8];
	assign rows.row7 = bar[7:0];

endmodule

`default_nettype wire

### rtl/signed_number_to_led_matrix_rows.sv
// Top level: signed number to 8x8 LED matrix rows, two-register pipeline.
// Depends on sntl_pkg, sntl_in_if, sntl_out_if, sntl_split, sntl_render.
//
// Usage:
//   sample : sink of signed 16-bit values; a beat moves on valid && ready.
//   matrix : source of row0..row7 images, one beat per accepted value.
//   Each value is clamped to +/-1999; rows 0..4 carry the hundreds and tens
//   glyphs, row2 bit 7 the minus sign, row5 bit 7 the thousands flag, rows
//   6..7 the bar graph for the units digit.
// Timing:
//   An accepted beat lands in the input register; once the result stage is
//   free it moves through clamp, digit split and glyph lookup into the
//   result register.
//   Throughput is one beat per cycle while matrix.ready stays high, set by
//   the single pass between the two registers.
// Reset: arst_n clears both stage valids; no result is pending afterward.
// Stall: while matrix.ready is low the result holds; the input register
//   still takes one more beat, then sample.ready drops until space frees.
`default_nettype none

module signed_number_to_led_matrix_rows
	import sntl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sntl_in_if.sink    sample,
	sntl_out_if.source matrix
);

	logic                      valid_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      valid_s2;
	rows_t                     rows_s2;

	logic    adv_s2;
	logic    take;
	digits_t digits;
	rows_t   rows;

	// result stage frees when empty or being drained
	assign adv_s2       = !valid_s2 || matrix.ready;
	assign sample.ready = !valid_s1 || adv_s2;
	assign take         = sample.valid && sample.ready;

	sntl_split u_split (
		.value  (value_s1),
		.digits (digits)
	);

	sntl_render u_render (
		.digits (digits),
		.rows   (rows)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !adv_s2);
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_s1 <= sample.value;
		end
		if (adv_s2 && valid_s1) begin
			rows_s2 <= rows;
		end
	end

	assign matrix.valid = valid_s2;
	assign matrix.row0  = rows_s2.row0;
	assign matrix.row1  = rows_s2.row1;
	assign matrix.row2  = rows_s2.row2;
	assign matrix.row3  = rows_s2.row3;
	assign matrix.row4  = rows_s2.row4;
	assign matrix.row5  = rows_s2.row5;
	assign matrix.row6  = rows_s2.row6;
	assign matrix.row7  = rows_s2.row7;

`ifndef SYNTH
	// accepted beat always occupies the input register next cycle
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted beat lost from input register");

	// both stages full and output stalled: no room for another beat
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !matrix.ready) |-> !sample.ready)
		else $error("input accepted with pipeline full");

	// thousands row carries only its flag bit
	a_row5_clean: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |-> (matrix.row5[6:0] == 7'd0))
		else $error("row5 low bits set");

	// bit 7 of glyph rows other than the sign row stays dark
	a_glyph_msb: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |-> !(matrix.row0[7] || matrix.row1[7] || matrix.row3[7]
			|| matrix.row4[7]))
		else $error("glyph row bit 7 set");
`endif

endmodule

`default_nettype wire
